@@ rtl/core/tpa_pkg.sv @@
// Package for the three point angle unit: widths, pipeline stage types and the
// CORDIC arctangent table. No dependencies; imported by every rtl/core module.
`timescale 1ns / 1ps
`default_nettype none

package tpa_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int NUM_COORDS  = 9;
    localparam int S_DATA_W    = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W    = 16;

    // difference vectors
    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int MAG_W    = COORD_WIDTH;
    localparam int NORM_TOP = 24;
    localparam int NW       = NORM_TOP + 1;

    // products and reduction
    localparam int PROD_W     = 2 * NW;
    localparam int SUM_W      = PROD_W + 2;
    localparam int PROD_SHIFT = 20;
    localparam int CROSS_W    = 29;
    localparam int DOT_W      = 31;
    localparam int SQ_W       = 60;

    // square root
    localparam int ROOT_W = SQ_W / 2;
    localparam int REM_W  = SQ_W + 2;

    // CORDIC
    localparam int XY_W  = 34;
    localparam int Z_W   = 32;
    localparam int STEPS = 27;
    localparam int Z_90  = 90 * (1 << 20);
    localparam int Z_180 = 180 * (1 << 20);

    localparam int ROUND_SH   = 12;
    localparam int ROUND_HALF = 1 << (ROUND_SH - 1);
    localparam int ANGLE_MAX  = 46080;

    // atan(2^-i) in degrees, 20 fraction bits
    localparam int ATAN_TAB [0:STEPS-1] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
        469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    typedef struct packed {
        logic                valid;
        logic                degen;
        logic [2:0][NW-1:0]  ba;
        logic [2:0][NW-1:0]  bc;
    } vec_t;

    typedef struct packed {
        logic             valid;
        logic             degen;
        logic [DOT_W-1:0] dot;
        logic [SQ_W-1:0]  sumsq;
    } prod_t;

    typedef struct packed {
        logic              valid;
        logic              degen;
        logic [DOT_W-1:0]  dot;
        logic [ROOT_W-1:0] root;
    } root_t;

    typedef struct packed {
        logic           valid;
        logic           degen;
        logic [Z_W-1:0] z;
    } ang_t;

endpackage

`default_nettype wire

@@ rtl/core/tpa_vec_prep.sv @@
// Difference vectors BA and BC and their normalization (three stages).
// Depends on tpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpa_vec_prep
    import tpa_pkg::*;
(
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    ce,
    input  wire logic                                    in_valid,
    input  wire logic [NUM_COORDS-1:0][COORD_WIDTH-1:0]  coords,
    output vec_t                                         vout
);

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] da_reg [0:2];
    logic signed [DIFF_W-1:0] dc_reg [0:2];
    logic signed [DIFF_W-1:0] da_next [0:2];
    logic signed [DIFF_W-1:0] dc_next [0:2];

    logic [MAG_W-1:0] ma_reg [0:2];
    logic [MAG_W-1:0] mc_reg [0:2];
    logic [2:0]       sa_reg, sc_reg;
    logic [MAG_W-1:0] maxa_reg, maxc_reg;
    logic             dg2_reg;
    logic [MAG_W-1:0] ma_next [0:2];
    logic [MAG_W-1:0] mc_next [0:2];
    logic [MAG_W-1:0] maxa_next, maxc_next;

    logic                dg3_reg;
    logic [2:0][NW-1:0]  ba_reg, bc_reg;
    logic [2:0][NW-1:0]  ba_next, bc_next;

    function automatic logic [MAG_W-1:0] abs_diff(logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] t;
        t = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return t[MAG_W-1:0];
    endfunction

    function automatic logic [NW-1:0] norm_comp(logic [MAG_W-1:0] mg, logic sg,
                                                 logic [MAG_W-1:0] mx);
        int                         p;
        logic [MAG_W+NORM_TOP-1:0]  wide;
        logic [NORM_TOP-1:0]        nm;
        logic [NW-1:0]              r;
        p = 0;
        for (int i = 0; i < MAG_W; i++) begin
            if (mx[i]) begin
                p = i;
            end
        end
        wide = '0;
        if (p >= NORM_TOP - 1) begin
            nm = NORM_TOP'(mg >> (p - (NORM_TOP - 1)));
        end else begin
            wide = {{NORM_TOP{1'b0}}, mg} << (NORM_TOP - 1 - p);
            nm   = wide[NORM_TOP-1:0];
        end
        r = {1'b0, nm};
        if (sg) begin
            r = -r;
        end
        return r;
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            da_next[k] = DIFF_W'($signed(coords[k]))     - DIFF_W'($signed(coords[3+k]));
            dc_next[k] = DIFF_W'($signed(coords[6+k]))   - DIFF_W'($signed(coords[3+k]));
            ma_next[k] = abs_diff(da_reg[k]);
            mc_next[k] = abs_diff(dc_reg[k]);
        end
        maxa_next = ma_next[0];
        if (ma_next[1] > maxa_next) maxa_next = ma_next[1];
        if (ma_next[2] > maxa_next) maxa_next = ma_next[2];
        maxc_next = mc_next[0];
        if (mc_next[1] > maxc_next) maxc_next = mc_next[1];
        if (mc_next[2] > maxc_next) maxc_next = mc_next[2];
        for (int k = 0; k < 3; k++) begin
            ba_next[k] = norm_comp(ma_reg[k], sa_reg[k], maxa_reg);
            bc_next[k] = norm_comp(mc_reg[k], sc_reg[k], maxc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                da_reg[k] <= da_next[k];
                dc_reg[k] <= dc_next[k];
                ma_reg[k] <= ma_next[k];
                mc_reg[k] <= mc_next[k];
                sa_reg[k] <= da_reg[k][DIFF_W-1];
                sc_reg[k] <= dc_reg[k][DIFF_W-1];
            end
            maxa_reg <= maxa_next;
            maxc_reg <= maxc_next;
            dg2_reg  <= (maxa_next == '0) || (maxc_next == '0);
            dg3_reg  <= dg2_reg;
            ba_reg   <= ba_next;
            bc_reg   <= bc_next;
        end
    end

    assign vout.valid = v3_reg;
    assign vout.degen = dg3_reg;
    assign vout.ba    = ba_reg;
    assign vout.bc    = bc_reg;

endmodule

`default_nettype wire

@@ rtl/core/tpa_products.sv @@
// Dot and cross products, reduction and sum of squared cross terms (five stages).
// Depends on tpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpa_products
    import tpa_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  ce,
    input  wire vec_t  vin,
    output prod_t      pout
);

    logic [4:0] v_reg;
    logic [4:0] dg_reg;

    logic signed [PROD_W-1:0] prod_reg  [0:2][0:2];
    logic signed [PROD_W-1:0] prod_next [0:2][0:2];

    logic signed [SUM_W-1:0] sum_reg  [0:3];
    logic signed [SUM_W-1:0] sum_next [0:3];

    logic [DOT_W-1:0]   dot6_reg, dot7_reg, dot8_reg;
    logic [DOT_W-1:0]   dot_next;
    logic [CROSS_W-1:0] crs_reg  [0:2];
    logic [CROSS_W-1:0] crs_next [0:2];
    logic [SUM_W-1:0]   smag [0:3];
    logic [SUM_W-1:0]   ssh  [0:3];

    logic [2*CROSS_W-1:0] sq_reg [0:2];
    logic [SQ_W-1:0]      sumsq_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = $signed(vin.ba[i]) * $signed(vin.bc[j]);
            end
        end
        sum_next[0] = SUM_W'(prod_reg[0][0]) + SUM_W'(prod_reg[1][1]) + SUM_W'(prod_reg[2][2]);
        sum_next[1] = SUM_W'(prod_reg[1][2]) - SUM_W'(prod_reg[2][1]);
        sum_next[2] = SUM_W'(prod_reg[2][0]) - SUM_W'(prod_reg[0][2]);
        sum_next[3] = SUM_W'(prod_reg[0][1]) - SUM_W'(prod_reg[1][0]);
        for (int k = 0; k < 4; k++) begin
            smag[k] = sum_reg[k][SUM_W-1] ? SUM_W'(-sum_reg[k]) : SUM_W'(sum_reg[k]);
            ssh[k]  = smag[k] >> PROD_SHIFT;
        end
        dot_next = sum_reg[0][SUM_W-1] ? DOT_W'(-ssh[0]) : DOT_W'(ssh[0]);
        for (int k = 0; k < 3; k++) begin
            crs_next[k] = ssh[k+1][CROSS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[3:0], vin.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dg_reg   <= {dg_reg[3:0], vin.degen};
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            dot6_reg <= dot_next;
            crs_reg  <= crs_next;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= crs_reg[k] * crs_reg[k];
            end
            dot7_reg  <= dot6_reg;
            sumsq_reg <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
            dot8_reg  <= dot7_reg;
        end
    end

    assign pout.valid = v_reg[4];
    assign pout.degen = dg_reg[4];
    assign pout.dot   = dot8_reg;
    assign pout.sumsq = sumsq_reg;

endmodule

`default_nettype wire

@@ rtl/core/tpa_isqrt.sv @@
// Pipelined integer square root of the cross-product length, one root bit per
// stage. Depends on tpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpa_isqrt
    import tpa_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   ce,
    input  wire prod_t  pin,
    output root_t       rout
);

    logic              st_v    [0:ROOT_W];
    logic              st_dg   [0:ROOT_W];
    logic [DOT_W-1:0]  st_dot  [0:ROOT_W];
    logic [REM_W-1:0]  st_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] st_root [0:ROOT_W];

    logic              v_reg    [0:ROOT_W-1];
    logic              dg_reg   [0:ROOT_W-1];
    logic [DOT_W-1:0]  dot_reg  [0:ROOT_W-1];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];

    assign st_v[0]    = pin.valid;
    assign st_dg[0]   = pin.degen;
    assign st_dot[0]  = pin.dot;
    assign st_rem[0]  = REM_W'(pin.sumsq);
    assign st_root[0] = '0;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_step
        localparam int B = ROOT_W - 1 - g;
        logic [REM_W-1:0] trial;
        logic             take;

        always_comb begin
            trial = (REM_W'(st_root[g]) << (B + 1)) + (REM_W'(1) << (2 * B));
            take  = st_rem[g] >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (ce) begin
                v_reg[g] <= st_v[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                dg_reg[g]   <= st_dg[g];
                dot_reg[g]  <= st_dot[g];
                rem_reg[g]  <= take ? st_rem[g] - trial : st_rem[g];
                root_reg[g] <= take ? (st_root[g] | (ROOT_W'(1) << B)) : st_root[g];
            end
        end

        assign st_v[g+1]    = v_reg[g];
        assign st_dg[g+1]   = dg_reg[g];
        assign st_dot[g+1]  = dot_reg[g];
        assign st_rem[g+1]  = rem_reg[g];
        assign st_root[g+1] = root_reg[g];
    end

    assign rout.valid = st_v[ROOT_W];
    assign rout.degen = st_dg[ROOT_W];
    assign rout.dot   = st_dot[ROOT_W];
    assign rout.root  = st_root[ROOT_W];

endmodule

`default_nettype wire

@@ rtl/core/tpa_cordic.sv @@
// Vectoring CORDIC atan2(cross, dot) in degrees: quadrant stage plus one
// stage per iteration. Depends on tpa_pkg (ATAN_TAB).
`timescale 1ns / 1ps
`default_nettype none

module tpa_cordic
    import tpa_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   ce,
    input  wire root_t  rin,
    output ang_t        aout
);

    logic                   v_reg  [0:STEPS];
    logic                   dg_reg [0:STEPS];
    logic signed [XY_W-1:0] x_reg  [0:STEPS];
    logic signed [XY_W-1:0] y_reg  [0:STEPS];
    logic signed [Z_W-1:0]  z_reg  [0:STEPS];

    logic signed [XY_W-1:0] dot_ext, root_ext;
    logic signed [XY_W-1:0] x0_next, y0_next;
    logic signed [Z_W-1:0]  z0_next;

    always_comb begin
        dot_ext  = XY_W'($signed(rin.dot));
        root_ext = $signed(XY_W'(rin.root));
        if (dot_ext < 0) begin
            x0_next = root_ext;
            y0_next = -dot_ext;
            z0_next = Z_W'(Z_90);
        end else begin
            x0_next = dot_ext;
            y0_next = root_ext;
            z0_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (ce) begin
            v_reg[0] <= rin.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dg_reg[0] <= rin.degen;
            x_reg[0]  <= x0_next;
            y_reg[0]  <= y0_next;
            z_reg[0]  <= z0_next;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_iter
        logic signed [XY_W-1:0] dx, dy;

        always_comb begin
            dx = y_reg[g] >>> g;
            dy = x_reg[g] >>> g;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g+1] <= 1'b0;
            end else if (ce) begin
                v_reg[g+1] <= v_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                dg_reg[g+1] <= dg_reg[g];
                if (y_reg[g] > 0) begin
                    x_reg[g+1] <= x_reg[g] + dx;
                    y_reg[g+1] <= y_reg[g] - dy;
                    z_reg[g+1] <= z_reg[g] + Z_W'(ATAN_TAB[g]);
                end else begin
                    x_reg[g+1] <= x_reg[g] - dx;
                    y_reg[g+1] <= y_reg[g] + dy;
                    z_reg[g+1] <= z_reg[g] - Z_W'(ATAN_TAB[g]);
                end
            end
        end
    end

    assign aout.valid = v_reg[STEPS];
    assign aout.degen = dg_reg[STEPS];
    assign aout.z     = z_reg[STEPS];

endmodule

`default_nettype wire

@@ rtl/core/three_point_angle_unit.sv @@
// Three point angle unit: angle ABC of three 3D points, in degrees.
// Top level; depends on tpa_pkg, tpa_vec_prep, tpa_products, tpa_isqrt, tpa_cordic.
//
// Usage:
//   s_ channel: one transaction carries A, B (vertex) and C, nine signed
//   24-bit coordinates with 10 fraction bits.
//   m_ channel: one transaction per input, angle in degrees (8 fraction
//   bits, 0..46080) and a degenerate flag, set with angle 0 when BA or BC
//   is the zero vector.
//   Stages from input transaction to m_tvalid: 3 vector prep, 5 product,
//   30 square root (one root bit each), 28 CORDIC and 1 output register.
//   Throughput: one transaction per cycle while the output is not stalled;
//   every stage is a pipeline register.
//   Reset: aresetn low clears all valid bits; in-flight transactions are lost.
//   Stall: when m_tready is low with a result held, the pipeline keeps moving
//   while its last stage is empty, so bubbles close up; once the last stage is
//   full the whole pipeline holds and s_tready drops. Nothing is lost or
//   repeated.
`timescale 1ns / 1ps
`default_nettype none

module three_point_angle_unit
    import tpa_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // end_a_x, end_a_y, end_a_z, vertex_x, vertex_y, vertex_z,
    // end_c_x, end_c_y, end_c_z (24 bits each, from bit 0)
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // angle_deg [15:0]
    output logic [M_DATA_W-1:0]      m_tdata,
    // degenerate [0]
    output logic                     m_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready
);

    vec_t  vec_s;
    prod_t prod_s;
    root_t root_s;
    ang_t  ang_s;

    logic out_load;
    logic ce;

    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic                  m_tuser_reg;

    logic signed [Z_W-1:0] z_clamp;
    logic [Z_W-1:0]        z_round;
    logic [M_DATA_W-1:0]   angle_next;

    assign out_load = !m_tvalid_reg || m_tready;
    assign ce       = out_load || !ang_s.valid;
    assign s_tready = ce;

    tpa_vec_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (s_tvalid),
        .coords   (s_tdata[NUM_COORDS*COORD_WIDTH-1:0]),
        .vout     (vec_s)
    );

    tpa_products u_prod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .vin     (vec_s),
        .pout    (prod_s)
    );

    tpa_isqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .pin     (prod_s),
        .rout    (root_s)
    );

    tpa_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .rin     (root_s),
        .aout    (ang_s)
    );

    always_comb begin
        z_clamp = $signed(ang_s.z);
        if (z_clamp < 0) begin
            z_clamp = '0;
        end else if (z_clamp > Z_W'(Z_180)) begin
            z_clamp = Z_W'(Z_180);
        end
        z_round    = Z_W'(z_clamp) + Z_W'(ROUND_HALF);
        angle_next = ang_s.degen ? '0 : z_round[ROUND_SH+M_DATA_W-1:ROUND_SH];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= ang_s.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= angle_next;
            m_tuser_reg <= ang_s.degen;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result with nonzero angle");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= M_DATA_W'(ANGLE_MAX))
        else $error("angle above 180 degrees");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
